[src/sfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser package
// Shared types and constants for the frame parser and its channel store.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned BODY_BYTES  = FRAME_BYTES - 2;

    // Positions of body bytes within a frame body.
    localparam logic [2:0] POS_CHAN  = 3'd0;
    localparam logic [2:0] POS_STAT  = 3'd1;
    localparam logic [2:0] POS_TEMP0 = 3'd2;
    localparam logic [2:0] POS_TEMP3 = 3'd5;
    localparam logic [2:0] POS_CSUM  = 3'(BODY_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_WAIT2 = 2'd1,
        PH_BODY  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OUT_TEMP   = 2'd0,
        OUT_STATUS = 2'd1,
        OUT_CSUM   = 2'd2,
        OUT_CHAN   = 2'd3
    } t_outcome;

    // Request from the parser to the per-channel store.
    typedef struct packed {
        logic        rd_en;
        logic [7:0]  rd_slot;
        logic        wr_en;
        logic        wr_temp_en;
        logic [7:0]  wr_slot;
        logic [7:0]  wr_status;
        logic [31:0] wr_temp;
    } t_store_req;

endpackage

[src/sfp_chan_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser channel store
// Per-channel status and temperature memories with a registered read port.
// ----------------------------------------------------------------------------
module sfp_chan_store
    import sfp_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_store_req  i_req,
    output logic [31:0] o_rd_temp
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [31:0]             r_temp_mem [NUM_CHANNELS];
    logic [7:0]              r_stat_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_temp_vld;
    logic [31:0]             r_rd_temp;

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_in_range;

    assign rd_idx      = i_req.rd_slot[IDX_W-1:0];
    assign wr_idx      = i_req.wr_slot[IDX_W-1:0];
    assign rd_in_range = (9'(i_req.rd_slot) < 9'(NUM_CHANNELS));

    // Entries never written read as zero, which is their reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_vld <= '0;
        end else if (i_req.wr_en && i_req.wr_temp_en) begin
            r_temp_vld[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_stat_mem[wr_idx] <= i_req.wr_status;
            if (i_req.wr_temp_en) begin
                r_temp_mem[wr_idx] <= i_req.wr_temp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            if (rd_in_range && r_temp_vld[rd_idx]) begin
                r_rd_temp <= r_temp_mem[rd_idx];
            end else begin
                r_rd_temp <= '0;
            end
        end
    end

    assign o_rd_temp = r_rd_temp;

endmodule

[src/sensor_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser
// Hunts for the AA 55 header, collects a seven-byte body and reports one
// result per frame while updating the per-channel status and temperature.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle unless stalled and produces one result
// word on the byte that carries the checksum. The checksum is summed as body
// bytes arrive and the channel's stored temperature is fetched when the
// channel byte arrives, so the frame decision is one compare and a select in
// the cycle of the last byte. A result register decouples the two sides: the
// input stays ready while the result register is empty or being drained in
// the same cycle. After reset the per-channel stores read as zero at once.
// ----------------------------------------------------------------------------
module sensor_frame_parser
    import sfp_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_outcome,
    output logic [7:0]  o_channel_id,
    output logic [7:0]  o_status_code,
    output logic [31:0] o_stored_temperature
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_chan;
    logic [7:0]  r_status;
    logic [31:0] r_temp;
    logic [7:0]  r_sum;

    logic        r_out_valid;
    t_outcome    r_outcome;
    logic [7:0]  r_out_chan;
    logic [7:0]  r_out_status;
    logic [31:0] r_out_temp;

    logic        accept;
    logic        finish;
    logic        csum_ok;
    logic        chan_ok;
    t_outcome    outcome;
    logic [31:0] held;
    logic [31:0] rd_temp;
    t_store_req  store_req;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign finish     = accept && (r_phase == PH_BODY) && (r_count == POS_CSUM);

    // Header hunt and body position.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte_in == HDR_FIRST) begin
                        n_phase = PH_WAIT2;
                    end
                end
                PH_WAIT2: begin
                    priority if (i_byte_in == HDR_SECOND) begin
                        n_phase = PH_BODY;
                        n_count = '0;
                    end else if (i_byte_in != HDR_FIRST) begin
                        n_phase = PH_HUNT;
                    end else begin
                        // A repeated first header byte keeps waiting for the second.
                        n_phase = PH_WAIT2;
                    end
                end
                PH_BODY: begin
                    if (r_count == POS_CSUM) begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 3'd1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Body capture: the checksum runs over the six bytes before it.
    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_BODY)) begin
            if (r_count == POS_CHAN) begin
                r_chan <= i_byte_in;
                r_sum  <= i_byte_in;
            end else if (r_count != POS_CSUM) begin
                r_sum <= r_sum + i_byte_in;
            end
            if (r_count == POS_STAT) begin
                r_status <= i_byte_in;
            end
            if ((r_count >= POS_TEMP0) && (r_count <= POS_TEMP3)) begin
                r_temp <= {i_byte_in, r_temp[31:8]};
            end
        end
    end

    // Frame decision on the checksum byte.
    always_comb begin
        csum_ok = (r_sum == i_byte_in);
        chan_ok = (r_chan != 8'd0) && (9'(r_chan) <= 9'(NUM_CHANNELS));
        held    = '0;
        priority if (!csum_ok) begin
            outcome = OUT_CSUM;
            if (chan_ok) begin
                held = rd_temp;
            end
        end else if (!chan_ok) begin
            outcome = OUT_CHAN;
        end else if (r_status == 8'd0) begin
            outcome = OUT_TEMP;
            held    = r_temp;
        end else begin
            outcome = OUT_STATUS;
            held    = rd_temp;
        end

        store_req.rd_en      = accept && (r_phase == PH_BODY) && (r_count == POS_CHAN);
        store_req.rd_slot    = i_byte_in - 8'd1;
        store_req.wr_en      = finish && csum_ok && chan_ok;
        store_req.wr_temp_en = (r_status == 8'd0);
        store_req.wr_slot    = r_chan - 8'd1;
        store_req.wr_status  = r_status;
        store_req.wr_temp    = r_temp;
    end

    sfp_chan_store #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_temp (rd_temp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_outcome    <= outcome;
            r_out_chan   <= r_chan;
            r_out_status <= r_status;
            r_out_temp   <= held;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_outcome            = r_outcome;
    assign o_channel_id         = r_out_chan;
    assign o_status_code        = r_out_status;
    assign o_stored_temperature = r_out_temp;

endmodule

[tb/tb_sensor_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser testbench
// Feeds header-framed byte streams with good and corrupted checksums, valid
// and out-of-range channels, repeated and broken headers and line noise,
// with random gaps and result stalls. A frame tracker predicts every report
// and checks each one against the parser's output.
// ----------------------------------------------------------------------------
module tb_sensor_frame_parser;
    import sfp_pkg::*;

    localparam int CHANNELS       = 4;
    localparam int TOTAL_BYTES    = 550;
    localparam int CALM_BYTES     = 70;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct {
        t_outcome    outcome;
        logic [7:0]  channel;
        logic [7:0]  status;
        logic [31:0] temperature;
    } t_report;

    // Tracks the header hunt, the body bytes and the per-channel stores, and
    // keeps the reports that the parser still owes.
    class frame_tracker;
        t_phase      phase;
        logic [3:0]  count;
        logic [7:0]  body [BODY_BYTES];
        logic [7:0]  status_mem [CHANNELS];
        logic [31:0] temp_mem [CHANNELS];
        t_report     owed_reports [$];
        int          errors;

        function new();
            phase  = PH_HUNT;
            count  = '0;
            errors = 0;
            foreach (body[i]) body[i] = '0;
            foreach (status_mem[i]) status_mem[i] = '0;
            foreach (temp_mem[i]) temp_mem[i] = '0;
        endfunction

        function void close_frame();
            logic [7:0] sum;
            logic       chan_ok;
            int         slot;
            t_report    rep;
            sum = '0;
            for (int i = 0; i < BODY_BYTES - 1; i++) sum = sum + body[i];
            chan_ok = (body[POS_CHAN] >= 8'd1) && (body[POS_CHAN] <= CHANNELS);
            slot = chan_ok ? int'(body[POS_CHAN]) - 1 : 0;
            rep.channel     = body[POS_CHAN];
            rep.status      = body[POS_STAT];
            rep.temperature = '0;
            if (sum != body[POS_CSUM]) begin
                rep.outcome = OUT_CSUM;
                if (chan_ok) rep.temperature = temp_mem[slot];
            end else if (!chan_ok) begin
                rep.outcome = OUT_CHAN;
            end else begin
                status_mem[slot] = body[POS_STAT];
                if (body[POS_STAT] == 8'd0) begin
                    temp_mem[slot] = {body[POS_TEMP3], body[POS_TEMP0 + 2],
                                      body[POS_TEMP0 + 1], body[POS_TEMP0]};
                    rep.outcome = OUT_TEMP;
                end else begin
                    rep.outcome = OUT_STATUS;
                end
                rep.temperature = temp_mem[slot];
            end
            owed_reports.push_back(rep);
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                PH_WAIT2: begin
                    if (b == HDR_SECOND) begin
                        count = '0;
                        phase = PH_BODY;
                    end else if (b != HDR_FIRST) begin
                        phase = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    body[count] = b;
                    count = count + 4'd1;
                    if (count == BODY_BYTES) begin
                        close_frame();
                        count = '0;
                        phase = PH_HUNT;
                    end
                end
                default: phase = (b == HDR_FIRST) ? PH_WAIT2 : PH_HUNT;
            endcase
        endfunction

        function void match_report(logic [1:0] outcome, logic [7:0] channel,
                                   logic [7:0] status, logic [31:0] temperature);
            t_report exp;
            if (owed_reports.size() == 0) begin
                $display("%0t: report with none owed: outcome %0d channel %0d",
                         $time, outcome, channel);
                errors++;
                return;
            end
            exp = owed_reports.pop_front();
            if (outcome !== exp.outcome) begin
                $display("%0t: outcome expected %0d got %0d", $time, exp.outcome, outcome);
                errors++;
            end
            if (channel !== exp.channel) begin
                $display("%0t: channel expected %0d got %0d", $time, exp.channel, channel);
                errors++;
            end
            if (status !== exp.status) begin
                $display("%0t: status expected %0d got %0d", $time, exp.status, status);
                errors++;
            end
            if (temperature !== exp.temperature) begin
                $display("%0t: temperature expected %h got %h",
                         $time, exp.temperature, temperature);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_byte_in = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_outcome;
    logic [7:0]  o_channel_id;
    logic [7:0]  o_status_code;
    logic [31:0] o_stored_temperature;

    frame_tracker tracker = new();
    int  bytes_sent = 0;
    int  idle_cycles = 0;
    bit  calm_tail = 1'b0;
    bit  sender_gaps = 1'b1;

    sensor_frame_parser #(
        .NUM_CHANNELS(CHANNELS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_byte_in           (i_byte_in),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_outcome           (o_outcome),
        .o_channel_id        (o_channel_id),
        .o_status_code       (o_status_code),
        .o_stored_temperature(o_stored_temperature)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // A report always follows the byte that caused it, so it is checked before
    // the byte taken at the same edge is applied to the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                tracker.match_report(o_outcome, o_channel_id, o_status_code,
                                     o_stored_temperature);
            end
            if (i_in_valid && o_in_ready) tracker.take_byte(i_byte_in);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: ready in random bursts, with random stalls.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (!calm_tail && $urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        if (!calm_tail && sender_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] channel, input logic [7:0] status,
                              input logic [31:0] temperature, input bit corrupt,
                              input int extra_first);
        logic [7:0] sum;
        sum = channel + status + temperature[7:0] + temperature[15:8]
            + temperature[23:16] + temperature[31:24];
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(HDR_FIRST);
        repeat (extra_first) send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(channel);
        send_byte(status);
        send_byte(temperature[7:0]);
        send_byte(temperature[15:8]);
        send_byte(temperature[23:16]);
        send_byte(temperature[31:24]);
        send_byte(sum);
    endtask

    task automatic send_random_frame();
        logic [7:0]  channel;
        logic [7:0]  status;
        logic [31:0] temperature;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) channel = 8'($urandom_range(1, CHANNELS));
        else if (pick == 7) channel = 8'h00;
        else if (pick == 8) channel = 8'($urandom_range(CHANNELS + 1, 254));
        else channel = 8'hFF;
        status = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
        case ($urandom_range(0, 7))
            0: temperature = 32'h0000_0000;
            1: temperature = 32'hFFFF_FFFF;
            default: temperature = $urandom();
        endcase
        send_frame(channel, status, temperature, $urandom_range(0, 5) == 0,
                   ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 3)) : 0);
    endtask

    // Line noise, or a header whose second word is wrong.
    task automatic send_noise();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
        end else begin
            b = 8'($urandom());
            if (b == HDR_SECOND || b == HDR_FIRST) b = 8'h00;
            send_byte(HDR_FIRST);
            send_byte(b);
        end
    endtask

    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_reports.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes of every field and every outcome.
        send_byte(8'h00);
        send_frame(8'd4, 8'h00, 32'hFFFF_FFFF, 1'b0, 1);
        send_byte(HDR_FIRST);
        send_byte(8'h13);
        send_frame(8'hFF, 8'hFF, 32'h0000_0000, 1'b0, 0);
        send_frame(8'd4, 8'h80, 32'h1234_5678, 1'b1, 0);
        send_frame(8'd4, 8'h01, 32'h89AB_CDEF, 1'b0, 0);
        send_frame(8'd1, 8'h00, 32'h0000_0000, 1'b0, 0);
        send_frame(8'h00, 8'h7F, 32'hA5A5_5A5A, 1'b1, 0);
        wait_for_reports();

        while (bytes_sent < TOTAL_BYTES) begin
            calm_tail = (bytes_sent >= TOTAL_BYTES - CALM_BYTES);
            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_random_frame();
            if (!calm_tail && $urandom_range(0, 14) == 0) wait_for_reports();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.owed_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
